// ===== rtl/core/cpq_pkg.sv =====
// Shared constants, codes and types for the class priority queue.
`timescale 1ns / 1ps

package cpq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int HANDLE_BITS = 16;
    localparam int NUM_CLASSES = 5;

    localparam int ID_W      = 64;
    localparam int TYPE_W    = 3;
    localparam int REF_W     = 16;
    localparam int CMD_W     = 2;
    localparam int CNT_OUT_W = 6;
    localparam int DROP_W    = 32;

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int CLS_W     = $clog2(NUM_CLASSES);

    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [TYPE_W-1:0] PT_CONFIG   = 3'd0;
    localparam logic [TYPE_W-1:0] PT_ACK      = 3'd1;
    localparam logic [TYPE_W-1:0] PT_TEXT     = 3'd2;
    localparam logic [TYPE_W-1:0] PT_SNAPSHOT = 3'd3;
    localparam logic [TYPE_W-1:0] PT_PRESENCE = 3'd5;
    localparam logic [TYPE_W-1:0] PT_PROBE    = 3'd6;

    localparam logic [CLS_W-1:0] CLS_CONFIG   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ACK      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_TEXT     = 3'd2;
    localparam logic [CLS_W-1:0] CLS_SNAPSHOT = 3'd3;
    localparam logic [CLS_W-1:0] CLS_VIDEO    = 3'd4;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_en;
        logic load_out;
    } cpq_ctl_t;

    typedef struct packed {
        logic is_pop;
    } cpq_sts_t;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [HANDLE_BITS-1:0] handle;
        logic                   reliable;
        logic [TYPE_W-1:0]      ptype;
    } entry_t;

    function automatic logic [CLS_W-1:0] class_of(input logic [TYPE_W-1:0] ptype);
        logic [CLS_W-1:0] cls;
        unique case (ptype)
            PT_CONFIG:             cls = CLS_CONFIG;
            PT_ACK, PT_PROBE:      cls = CLS_ACK;
            PT_TEXT, PT_PRESENCE:  cls = CLS_TEXT;
            PT_SNAPSHOT:           cls = CLS_SNAPSHOT;
            default:               cls = CLS_VIDEO;
        endcase
        return cls;
    endfunction

endpackage

// ===== rtl/core/cpq_datapath.sv =====
// Datapath: descriptor store, per-class ring pointers, drop counter, result register.
`timescale 1ns / 1ps

module cpq_datapath import cpq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cpq_ctl_t             ctl,
    output cpq_sts_t             sts,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [TYPE_W-1:0]    s_payload_type,
    input  logic [ID_W-1:0]      s_msg_id,
    input  logic                 s_reliable,
    input  logic [REF_W-1:0]     s_payload_ref,
    output logic                 m_out_valid,
    output logic [TYPE_W-1:0]    m_out_type,
    output logic [ID_W-1:0]      m_out_msg_id,
    output logic                 m_out_reliable,
    output logic [REF_W-1:0]     m_out_payload_ref,
    output logic [CNT_OUT_W-1:0] m_count_config,
    output logic [CNT_OUT_W-1:0] m_count_ack,
    output logic [CNT_OUT_W-1:0] m_count_text,
    output logic [CNT_OUT_W-1:0] m_count_snapshot,
    output logic [CNT_OUT_W-1:0] m_count_video,
    output logic [DROP_W-1:0]    m_dropped_total
);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] h);
        return (h == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : SLOT_W'(h + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] mem_idx(input logic [CLS_W-1:0] cls,
                                                 input logic [SLOT_W-1:0] slot);
        return IDX_W'(IDX_W'(cls) * IDX_W'(QUEUE_DEPTH)) + IDX_W'(slot);
    endfunction

    logic [CMD_W-1:0]   cmd_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic [ID_W-1:0]    id_reg;
    logic               rel_reg;
    logic [REF_W-1:0]   ref_reg;

    logic [SLOT_W-1:0]  head_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]   count_reg [NUM_CLASSES];
    logic [DROP_W-1:0]  drop_reg;
    logic               hit_reg;

    entry_t             mem [MEM_DEPTH];
    entry_t             rd_data_reg;

    logic [CLS_W-1:0]   enq_cls;
    logic [SUM_W-1:0]   slot_sum;
    logic [SLOT_W-1:0]  enq_slot;
    logic [IDX_W-1:0]   wr_idx;
    logic [CLS_W-1:0]   pop_cls;
    logic               pop_found;
    logic [IDX_W-1:0]   rd_idx;
    entry_t             wr_entry;
    logic               enq_full;

    // Hold the accepted transaction.
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg  <= s_cmd;
            type_reg <= s_payload_type;
            id_reg   <= s_msg_id;
            rel_reg  <= s_reliable;
            ref_reg  <= s_payload_ref;
        end
    end

    assign sts.is_pop = (cmd_reg == CMD_POP);

    // Tail slot = (head + count) mod depth; the sum stays below twice the depth.
    always_comb begin
        enq_cls  = class_of(type_reg);
        slot_sum = SUM_W'(head_reg[enq_cls]) + SUM_W'(count_reg[enq_cls]);
        if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
            enq_slot = SLOT_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            enq_slot = SLOT_W'(slot_sum);
        end
        wr_idx   = mem_idx(enq_cls, enq_slot);
        enq_full = (count_reg[enq_cls] == CNT_W'(QUEUE_DEPTH));
        wr_entry = '{id: id_reg, handle: HANDLE_BITS'(ref_reg),
                     reliable: rel_reg, ptype: type_reg};
    end

    // Strict priority: lowest non-empty class wins.
    always_comb begin
        pop_cls   = CLS_VIDEO;
        pop_found = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (count_reg[c] != '0) begin
                pop_cls   = CLS_W'(c);
                pop_found = 1'b1;
            end
        end
        rd_idx = mem_idx(pop_cls, head_reg[pop_cls]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            drop_reg <= '0;
            hit_reg  <= 1'b0;
        end else if (ctl.exec) begin
            hit_reg <= pop_found;
            unique case (cmd_reg)
                CMD_ENQ: begin
                    if (enq_full) begin
                        head_reg[enq_cls] <= next_slot(head_reg[enq_cls]);
                        if (drop_reg != '1) begin
                            drop_reg <= drop_reg + 1'b1;
                        end
                    end else begin
                        count_reg[enq_cls] <= count_reg[enq_cls] + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (pop_found) begin
                        head_reg[pop_cls]  <= next_slot(head_reg[pop_cls]);
                        count_reg[pop_cls] <= count_reg[pop_cls] - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    for (int c = 0; c < NUM_CLASSES; c++) begin
                        head_reg[c]  <= '0;
                        count_reg[c] <= '0;
                    end
                    drop_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Descriptor store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (ctl.exec && (cmd_reg == CMD_ENQ)) begin
            mem[wr_idx] <= wr_entry;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_count_config   <= CNT_OUT_W'(count_reg[CLS_CONFIG]);
            m_count_ack      <= CNT_OUT_W'(count_reg[CLS_ACK]);
            m_count_text     <= CNT_OUT_W'(count_reg[CLS_TEXT]);
            m_count_snapshot <= CNT_OUT_W'(count_reg[CLS_SNAPSHOT]);
            m_count_video    <= CNT_OUT_W'(count_reg[CLS_VIDEO]);
            m_dropped_total  <= drop_reg;
            unique case (cmd_reg)
                CMD_ENQ: begin
                    m_out_valid       <= 1'b1;
                    m_out_type        <= '0;
                    m_out_msg_id      <= id_reg;
                    m_out_reliable    <= 1'b0;
                    m_out_payload_ref <= '0;
                end
                CMD_POP: begin
                    m_out_valid       <= hit_reg;
                    m_out_type        <= hit_reg ? rd_data_reg.ptype : '0;
                    m_out_msg_id      <= hit_reg ? rd_data_reg.id : '0;
                    m_out_reliable    <= hit_reg & rd_data_reg.reliable;
                    m_out_payload_ref <= hit_reg ? REF_W'(rd_data_reg.handle) : '0;
                end
                default: begin
                    m_out_valid       <= 1'b0;
                    m_out_type        <= '0;
                    m_out_msg_id      <= '0;
                    m_out_reliable    <= 1'b0;
                    m_out_payload_ref <= '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/cpq_controller.sv =====
// Controller: sequences capture, execute and result load; owns both handshakes.
`timescale 1ns / 1ps

module cpq_controller import cpq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output cpq_ctl_t ctl,
    input  cpq_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;

    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctl.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                ctl.rd_en  = sts.is_pop;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold until the result register is free.
                ctl.load_out = !out_full_reg || m_ready;
                if (ctl.load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.load_out) begin
            out_full_next = 1'b1;
        end else if (m_ready) begin
            out_full_next = 1'b0;
        end else begin
            out_full_next = out_full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign m_valid = out_full_reg;

endmodule

// ===== rtl/core/class_priority_queue_drop_oldest_top.sv =====
// Top level of the five-class strict priority descriptor queue with drop-oldest overflow.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake           Payload
//  s_        in   s_valid / s_ready   cmd, payload_type, msg_id, reliable, payload_ref
//  m_        out  m_valid / m_ready   out_valid, out_type, out_msg_id, out_reliable,
//                                     out_payload_ref, count_*, dropped_total
//
//  Every transaction passes through capture, execute (store write or registered
//  read plus pointer update and five-way priority pick) and result load. The
//  single registered read port of the descriptor store sets the execute step.
//  Reset (aresetn low, synchronous) empties all classes and zeroes the drop count;
//  the descriptor store itself is not cleared, so no clearing pass is needed.
//  A new transaction is taken while the previous result waits in the output
//  register; a stalled m_ready holds the next result load until the slot frees.
//
module class_priority_queue_drop_oldest_top import cpq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [TYPE_W-1:0]    s_payload_type,
    input  logic [ID_W-1:0]      s_msg_id,
    input  logic                 s_reliable,
    input  logic [REF_W-1:0]     s_payload_ref,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_out_valid,
    output logic [TYPE_W-1:0]    m_out_type,
    output logic [ID_W-1:0]      m_out_msg_id,
    output logic                 m_out_reliable,
    output logic [REF_W-1:0]     m_out_payload_ref,
    output logic [CNT_OUT_W-1:0] m_count_config,
    output logic [CNT_OUT_W-1:0] m_count_ack,
    output logic [CNT_OUT_W-1:0] m_count_text,
    output logic [CNT_OUT_W-1:0] m_count_snapshot,
    output logic [CNT_OUT_W-1:0] m_count_video,
    output logic [DROP_W-1:0]    m_dropped_total
);

    cpq_ctl_t ctl;
    cpq_sts_t sts;

    // Sequence each transaction and own both handshakes.
    cpq_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .sts     (sts)
    );

    // Store descriptors, advance ring pointers, build the result.
    cpq_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .sts               (sts),
        .s_cmd             (s_cmd),
        .s_payload_type    (s_payload_type),
        .s_msg_id          (s_msg_id),
        .s_reliable        (s_reliable),
        .s_payload_ref     (s_payload_ref),
        .m_out_valid       (m_out_valid),
        .m_out_type        (m_out_type),
        .m_out_msg_id      (m_out_msg_id),
        .m_out_reliable    (m_out_reliable),
        .m_out_payload_ref (m_out_payload_ref),
        .m_count_config    (m_count_config),
        .m_count_ack       (m_count_ack),
        .m_count_text      (m_count_text),
        .m_count_snapshot  (m_count_snapshot),
        .m_count_video     (m_count_video),
        .m_dropped_total   (m_dropped_total)
    );

`ifndef ASSERT_OFF
    // A result load must never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten while still pending");

    // A new transaction is never captured while one is executing.
    a_capture_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.capture |-> (!ctl.exec && !ctl.load_out))
        else $error("capture overlaps execute or load");

    // Execute is always followed by the result step.
    a_exec_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec |=> !ctl.exec && !s_ready)
        else $error("execute not followed by result step");

    // Reported class counts never exceed the class depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_count_config) <= QUEUE_DEPTH)
                 && (32'(m_count_ack) <= QUEUE_DEPTH)
                 && (32'(m_count_text) <= QUEUE_DEPTH)
                 && (32'(m_count_snapshot) <= QUEUE_DEPTH)
                 && (32'(m_count_video) <= QUEUE_DEPTH))
        else $error("class count above depth");
`endif

endmodule
